// ----- design/svrlf_pkg.sv -----
package svrlf_pkg;

  // Input transaction modes.
  localparam logic [2:0] ModeReadReq    = 3'd0;
  localparam logic [2:0] ModeWriteReq   = 3'd1;
  localparam logic [2:0] ModeRxByte     = 3'd2;
  localparam logic [2:0] ModeRxError    = 3'd3;
  localparam logic [2:0] ModeNoServo    = 3'd4;
  localparam logic [2:0] ModeEndHigh    = 3'd5;
  localparam logic [2:0] ModeEndLow     = 3'd6;

  // Completion status codes.
  localparam logic [2:0] StatusOk       = 3'd0;
  localparam logic [2:0] StatusCorrupt  = 3'd1;
  localparam logic [2:0] StatusNoServo  = 3'd2;
  localparam logic [2:0] StatusNoPullup = 3'd3;
  localparam logic [2:0] StatusBusy     = 3'd4;

  // Frame bytes.
  localparam logic [7:0] HdrRequest     = 8'h96;
  localparam logic [7:0] HdrResponse    = 8'h69;
  localparam logic [7:0] LenTwo         = 8'h02;
  localparam logic [7:0] ZeroByte       = 8'h00;

  // Reply length in bytes and its counter width.
  localparam int unsigned ReplyLen      = 7;
  localparam int unsigned RxCntW        = 3;

  // Result kinds.
  localparam logic KindTx   = 1'b0;
  localparam logic KindDone = 1'b1;

  // Command queue between front and back.
  localparam int unsigned QueueDepth    = 4;
  localparam int unsigned QueuePtrW     = $clog2(QueueDepth);
  localparam int unsigned QueueCntW     = $clog2(QueueDepth + 1);

  // Position of a result within one command.
  localparam int unsigned IdxW          = 3;

  typedef enum logic [1:0] {
    CmdRead  = 2'd0,
    CmdWrite = 2'd1,
    CmdDone  = 2'd2
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e     op;
    logic [7:0]  reg_addr;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [7:0]  ck;
    logic [2:0]  status;
    logic [15:0] value;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [2:0]  status;
    logic [15:0] read_value;
  } res_t;

endpackage

// ----- design/svrlf_front.sv -----
module svrlf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [2:0]        mode_i,
  input  logic [7:0]        reg_addr_i,
  input  logic [15:0]       write_value_i,
  input  logic [7:0]        rx_byte_i,
  output logic              cmd_valid_o,
  output svrlf_pkg::cmd_t   cmd_o
);

  logic                          awaiting_q, awaiting_d;
  logic [svrlf_pkg::RxCntW-1:0]  rx_count_q, rx_count_d;
  logic [7:0]                    pending_q, pending_d;
  logic                          bad_q, bad_d;
  logic [7:0]                    sum_q, sum_d;
  logic [7:0]                    low_q, low_d;
  logic [7:0]                    high_q, high_d;
  logic                          full_reply;

  assign full_reply = (rx_count_q == svrlf_pkg::RxCntW'(svrlf_pkg::ReplyLen));

  always_comb begin
    awaiting_d  = awaiting_q;
    rx_count_d  = rx_count_q;
    pending_d   = pending_q;
    bad_d       = bad_q;
    sum_d       = sum_q;
    low_d       = low_q;
    high_d      = high_q;
    cmd_valid_o = 1'b0;
    cmd_o.op       = svrlf_pkg::CmdDone;
    cmd_o.reg_addr = reg_addr_i;
    cmd_o.lo       = write_value_i[7:0];
    cmd_o.hi       = write_value_i[15:8];
    cmd_o.ck       = reg_addr_i + svrlf_pkg::LenTwo + write_value_i[7:0] + write_value_i[15:8];
    cmd_o.status   = svrlf_pkg::StatusOk;
    cmd_o.value    = 16'd0;

    if (accept_i) begin
      if (mode_i == svrlf_pkg::ModeReadReq || mode_i == svrlf_pkg::ModeWriteReq) begin
        cmd_valid_o = 1'b1;
        if (awaiting_q) begin
          cmd_o.op     = svrlf_pkg::CmdDone;
          cmd_o.status = svrlf_pkg::StatusBusy;
        end else if (mode_i == svrlf_pkg::ModeReadReq) begin
          cmd_o.op   = svrlf_pkg::CmdRead;
          awaiting_d = 1'b1;
          rx_count_d = '0;
          bad_d      = 1'b0;
          sum_d      = 8'd0;
          pending_d  = reg_addr_i;
        end else begin
          cmd_o.op = svrlf_pkg::CmdWrite;
        end
      end else if (awaiting_q) begin
        unique case (mode_i)
          svrlf_pkg::ModeRxByte: begin
            if (!full_reply) begin
              rx_count_d = rx_count_q + 1'b1;
              unique case (rx_count_q)
                3'd0: if (rx_byte_i != svrlf_pkg::HdrResponse) bad_d = 1'b1;
                3'd1: sum_d = sum_q + rx_byte_i;
                3'd2: begin
                  if (rx_byte_i != pending_q) bad_d = 1'b1;
                  sum_d = sum_q + rx_byte_i;
                end
                3'd3: begin
                  if (rx_byte_i != svrlf_pkg::LenTwo) bad_d = 1'b1;
                  sum_d = sum_q + rx_byte_i;
                end
                3'd4: begin
                  low_d = rx_byte_i;
                  sum_d = sum_q + rx_byte_i;
                end
                3'd5: begin
                  high_d = rx_byte_i;
                  sum_d  = sum_q + rx_byte_i;
                end
                default: if (rx_byte_i != sum_q) bad_d = 1'b1;
              endcase
            end
          end
          svrlf_pkg::ModeRxError: begin
            if (!full_reply) begin
              rx_count_d = rx_count_q + 1'b1;
              bad_d      = 1'b1;
            end
          end
          svrlf_pkg::ModeNoServo, svrlf_pkg::ModeEndHigh, svrlf_pkg::ModeEndLow: begin
            cmd_valid_o = 1'b1;
            awaiting_d  = 1'b0;
            rx_count_d  = '0;
            bad_d       = 1'b0;
            sum_d       = 8'd0;
            if (mode_i == svrlf_pkg::ModeNoServo) begin
              cmd_o.status = svrlf_pkg::StatusNoServo;
            end else if (mode_i == svrlf_pkg::ModeEndLow) begin
              cmd_o.status = svrlf_pkg::StatusNoPullup;
            end else if (full_reply && !bad_q) begin
              cmd_o.status = svrlf_pkg::StatusOk;
              cmd_o.value  = {high_q, low_q};
            end else begin
              cmd_o.status = svrlf_pkg::StatusCorrupt;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q <= 1'b0;
      rx_count_q <= '0;
      pending_q  <= 8'd0;
      bad_q      <= 1'b0;
      sum_q      <= 8'd0;
      low_q      <= 8'd0;
      high_q     <= 8'd0;
    end else begin
      awaiting_q <= awaiting_d;
      rx_count_q <= rx_count_d;
      pending_q  <= pending_d;
      bad_q      <= bad_d;
      sum_q      <= sum_d;
      low_q      <= low_d;
      high_q     <= high_d;
    end
  end

endmodule

// ----- design/svrlf_cmd_queue.sv -----
module svrlf_cmd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  svrlf_pkg::cmd_t   push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output svrlf_pkg::cmd_t   head_o
);

  svrlf_pkg::cmd_t                     entry_q [svrlf_pkg::QueueDepth];
  logic [svrlf_pkg::QueuePtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [svrlf_pkg::QueueCntW-1:0]     count_q;
  logic                                do_push, do_pop;

  assign full_o  = (count_q == svrlf_pkg::QueueCntW'(svrlf_pkg::QueueDepth));
  assign valid_o = (count_q != '0);
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ----- design/svrlf_back.sv -----
module svrlf_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  svrlf_pkg::cmd_t   cmd_i,
  output logic              cmd_pop_o,
  output logic              res_valid_o,
  output svrlf_pkg::res_t   res_o,
  input  logic              res_pop_i
);

  logic [svrlf_pkg::IdxW-1:0] idx_q;
  logic [svrlf_pkg::IdxW-1:0] last_idx;
  logic                       out_valid_q;
  svrlf_pkg::res_t            out_q, res_d;
  logic                       advance, at_last;

  always_comb begin
    unique case (cmd_i.op)
      svrlf_pkg::CmdRead:  last_idx = 3'd4;
      svrlf_pkg::CmdWrite: last_idx = 3'd6;
      default:             last_idx = 3'd0;
    endcase
  end

  assign at_last   = (idx_q == last_idx);
  assign advance   = cmd_valid_i && (!out_valid_q || res_pop_i);
  assign cmd_pop_o = advance && at_last;

  always_comb begin
    res_d.kind       = svrlf_pkg::KindTx;
    res_d.last       = at_last;
    res_d.status     = svrlf_pkg::StatusOk;
    res_d.read_value = 16'd0;
    res_d.tx_byte    = svrlf_pkg::ZeroByte;
    if (cmd_i.op == svrlf_pkg::CmdDone) begin
      res_d.kind       = svrlf_pkg::KindDone;
      res_d.status     = cmd_i.status;
      res_d.read_value = cmd_i.value;
    end else begin
      unique case (idx_q)
        3'd0: res_d.tx_byte = svrlf_pkg::HdrRequest;
        3'd1: res_d.tx_byte = svrlf_pkg::ZeroByte;
        3'd2: res_d.tx_byte = cmd_i.reg_addr;
        3'd3: res_d.tx_byte = (cmd_i.op == svrlf_pkg::CmdRead) ? svrlf_pkg::ZeroByte
                                                               : svrlf_pkg::LenTwo;
        3'd4: res_d.tx_byte = (cmd_i.op == svrlf_pkg::CmdRead) ? cmd_i.reg_addr : cmd_i.lo;
        3'd5: res_d.tx_byte = cmd_i.hi;
        default: res_d.tx_byte = cmd_i.ck;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        idx_q       <= at_last ? '0 : idx_q + 1'b1;
      end else if (res_pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

// ----- design/servo_register_link_framer_core.sv -----
// Byte-level framer for a single-wire servo register link.
// Input channel: push/full. A transaction carries a mode (read request,
// write request, received byte, received byte with error, no servo, end of
// reply with the line high or low) and its payload fields.
// Result channel: empty/pop. Each result is either a byte to transmit or
// a completion with a status and the 16-bit register value.
// A read request yields five transmit bytes, a write request seven, and an
// end-of-reply or no-servo event during a reply one completion. A request made
// while a reply is still awaited yields a single busy completion.
// The front end updates the reply-tracking state in the cycle it accepts a
// transaction, so input transactions are taken back to back, one per cycle,
// while the four-entry command queue has room. The back end turns each
// queued command into results at one per cycle while the receiver keeps
// popping; each result is held in the output register while it is shown
// on the result port.
// When the receiver stalls, results wait in the output register, the queue
// fills, and full rises once all four entries are taken.
// Reset clears the reply state, the queue and the output valid flag.
module servo_register_link_framer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  mode_i,
  input  logic [7:0]  reg_addr_i,
  input  logic [15:0] write_value_i,
  input  logic [7:0]  rx_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic        kind_o,
  output logic [7:0]  tx_byte_o,
  output logic        last_o,
  output logic [2:0]  status_o,
  output logic [15:0] read_value_o
);

  logic             accept;
  logic             cmd_valid;
  svrlf_pkg::cmd_t  cmd;
  logic             head_valid;
  svrlf_pkg::cmd_t  head;
  logic             head_pop;
  logic             res_valid;
  svrlf_pkg::res_t  res;

  // Every accepted transaction goes through the front end; only those that
  // produce results occupy a queue entry.
  assign accept = push && !full;

  svrlf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .mode_i        (mode_i),
    .reg_addr_i    (reg_addr_i),
    .write_value_i (write_value_i),
    .rx_byte_i     (rx_byte_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd)
  );

  svrlf_cmd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cmd_valid),
    .push_data_i (cmd),
    .full_o      (full),
    .pop_i       (head_pop),
    .valid_o     (head_valid),
    .head_o      (head)
  );

  svrlf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (head_valid),
    .cmd_i       (head),
    .cmd_pop_o   (head_pop),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_pop_i   (pop)
  );

  assign empty        = !res_valid;
  assign kind_o       = res.kind;
  assign tx_byte_o    = res.tx_byte;
  assign last_o       = res.last;
  assign status_o     = res.status;
  assign read_value_o = res.read_value;

endmodule

// ----- tb/tb_servo_register_link_framer_core.sv -----
`timescale 1ns / 100ps

// Testbench for the servo register link framer.
// Every input transaction accepted by the block is run through a predictor
// kept inside this module, which queues the transmit bytes and read
// completions the block should return. A separate process checks each
// result transaction popped from the block against the oldest queued one.
module tb_servo_register_link_framer_core;

  // Mode 3'd7 has no name in the package; the block must ignore it.
  localparam logic [2:0] ModeUnused = 3'd7;

  localparam int ItemsTarget = 420;     // directed plus random input transactions
  localparam int CycleLimit  = 200000;  // watchdog, far above the slowest correct run
  localparam int DrainCycles = 16;      // quiet time after the last expected result
  localparam int IdlePct     = 11;      // chance of an idle cycle on either side
  localparam int StallCycles = 160;     // long receiver hold-off

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        push          = 1'b0;
  logic        pop           = 1'b0;
  logic [2:0]  mode_i        = svrlf_pkg::ModeRxByte;
  logic [7:0]  reg_addr_i    = 8'h00;
  logic [15:0] write_value_i = 16'h0000;
  logic [7:0]  rx_byte_i     = 8'h00;
  logic        full;
  logic        empty;
  logic        kind_o;
  logic [7:0]  tx_byte_o;
  logic        last_o;
  logic [2:0]  status_o;
  logic [15:0] read_value_o;

  servo_register_link_framer_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .mode_i        (mode_i),
    .reg_addr_i    (reg_addr_i),
    .write_value_i (write_value_i),
    .rx_byte_i     (rx_byte_i),
    .empty         (empty),
    .pop           (pop),
    .kind_o        (kind_o),
    .tx_byte_o     (tx_byte_o),
    .last_o        (last_o),
    .status_o      (status_o),
    .read_value_o  (read_value_o)
  );

  always #5 clk_i = ~clk_i;

  // Results the block still owes, oldest first.
  svrlf_pkg::res_t link_results[$];

  int   items_sent   = 0;
  int   mismatches   = 0;
  int   cycle_count  = 0;
  logic calm         = 1'b0;  // when set, neither side idles
  logic rx_hold      = 1'b0;  // receiver holds off while set
  int   hold_request = 0;     // cycles of hold-off asked by a test

  // Predictor copy of the reply-tracking state.
  logic       awaiting  = 1'b0;
  logic [3:0] rx_cnt    = '0;
  logic [7:0] pend_reg  = '0;
  logic       frame_bad = 1'b0;
  logic [7:0] sum_acc   = '0;
  logic [7:0] value_lo  = '0;
  logic [7:0] value_hi  = '0;

  function automatic void add_tx(logic [7:0] b, logic fin);
    link_results.push_back('{kind: svrlf_pkg::KindTx, tx_byte: b, last: fin,
                             status: svrlf_pkg::StatusOk, read_value: 16'h0000});
  endfunction

  function automatic void add_done(logic [2:0] st, logic [15:0] v);
    link_results.push_back('{kind: svrlf_pkg::KindDone, tx_byte: svrlf_pkg::ZeroByte,
                             last: 1'b1, status: st, read_value: v});
  endfunction

  // Leaving a reply clears the tracking state but keeps the last value
  // bytes and the pending register.
  function automatic void leave_reply();
    awaiting  = 1'b0;
    rx_cnt    = '0;
    frame_bad = 1'b0;
    sum_acc   = '0;
  endfunction

  // Works out what one accepted input transaction causes and queues it.
  function automatic void predict_link_results(logic [2:0] m, logic [7:0] r,
                                               logic [15:0] wv, logic [7:0] rb);
    logic [7:0] ck;
    if (m == svrlf_pkg::ModeReadReq || m == svrlf_pkg::ModeWriteReq) begin
      // A request while a reply is still awaited is dropped as busy.
      if (awaiting) begin
        add_done(svrlf_pkg::StatusBusy, 16'h0000);
      end else begin
        add_tx(svrlf_pkg::HdrRequest, 1'b0);
        add_tx(svrlf_pkg::ZeroByte, 1'b0);
        add_tx(r, 1'b0);
        if (m == svrlf_pkg::ModeReadReq) begin
          add_tx(svrlf_pkg::ZeroByte, 1'b0);
          add_tx(r, 1'b1);
          leave_reply();
          awaiting = 1'b1;
          pend_reg = r;
        end else begin
          ck = r + svrlf_pkg::LenTwo + wv[7:0] + wv[15:8];
          add_tx(svrlf_pkg::LenTwo, 1'b0);
          add_tx(wv[7:0], 1'b0);
          add_tx(wv[15:8], 1'b0);
          add_tx(ck, 1'b1);
        end
      end
    end else if (awaiting) begin
      // Bytes and line events are ignored while idle.
      case (m)
        svrlf_pkg::ModeRxByte: begin
          // Bytes past the seventh are dropped.
          if (rx_cnt < svrlf_pkg::ReplyLen) begin
            case (rx_cnt)
              4'd0: if (rb != svrlf_pkg::HdrResponse) frame_bad = 1'b1;
              4'd1: sum_acc = sum_acc + rb;
              4'd2: begin
                if (rb != pend_reg) frame_bad = 1'b1;
                sum_acc = sum_acc + rb;
              end
              4'd3: begin
                if (rb != svrlf_pkg::LenTwo) frame_bad = 1'b1;
                sum_acc = sum_acc + rb;
              end
              4'd4: begin
                value_lo = rb;
                sum_acc  = sum_acc + rb;
              end
              4'd5: begin
                value_hi = rb;
                sum_acc  = sum_acc + rb;
              end
              default: if (rb != sum_acc) frame_bad = 1'b1;
            endcase
            rx_cnt = rx_cnt + 4'd1;
          end
        end
        svrlf_pkg::ModeRxError: begin
          // An errored byte takes a slot but never enters the sum.
          if (rx_cnt < svrlf_pkg::ReplyLen) begin
            frame_bad = 1'b1;
            rx_cnt    = rx_cnt + 4'd1;
          end
        end
        svrlf_pkg::ModeNoServo: begin
          leave_reply();
          add_done(svrlf_pkg::StatusNoServo, 16'h0000);
        end
        svrlf_pkg::ModeEndHigh: begin
          if (rx_cnt == svrlf_pkg::ReplyLen && !frame_bad)
            add_done(svrlf_pkg::StatusOk, {value_hi, value_lo});
          else
            add_done(svrlf_pkg::StatusCorrupt, 16'h0000);
          leave_reply();
        end
        svrlf_pkg::ModeEndLow: begin
          leave_reply();
          add_done(svrlf_pkg::StatusNoPullup, 16'h0000);
        end
        default: ;
      endcase
    end
  endfunction

  // Sends one input transaction. Inputs change at the falling edge; the
  // transaction is taken at the first rising edge with full low, and only
  // then does the predictor see it. Push stays high into the next call so
  // back-to-back transactions need no gap.
  task automatic send_item(logic [2:0] m, logic [7:0] r, logic [15:0] wv,
                           logic [7:0] rb);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 99) < IdlePct) begin
      push = 1'b0;
      @(negedge clk_i);
    end
    push          = 1'b1;
    mode_i        = m;
    reg_addr_i    = r;
    write_value_i = wv;
    rx_byte_i     = rb;
    do @(posedge clk_i); while (full);
    predict_link_results(m, r, wv, rb);
    items_sent++;
  endtask

  // The sender goes quiet until every owed result has been popped.
  task automatic wait_for_drain();
    @(negedge clk_i);
    push = 1'b0;
    while (link_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] reply_sum(logic [7:0] b1, logic [7:0] r,
                                           logic [7:0] lo, logic [7:0] hi);
    return b1 + r + svrlf_pkg::LenTwo + lo + hi;
  endfunction

  // One read request and its reply. With damage, a single fault is put
  // into the reply: a bad header, echo, length or checksum, an errored
  // byte, a short or overlong reply, a low line at the end, a lost servo,
  // a request that hits the busy window, or an unused mode in the middle.
  task automatic run_read_exchange(bit damaged);
    logic [7:0] r;
    logic [7:0] frame [7];
    logic [2:0] req;
    int         fault;
    int         spot;
    int         n_bytes;
    r        = pick_byte();
    frame[0] = svrlf_pkg::HdrResponse;
    frame[1] = pick_byte();
    frame[2] = r;
    frame[3] = svrlf_pkg::LenTwo;
    frame[4] = pick_byte();
    frame[5] = pick_byte();
    frame[6] = reply_sum(frame[1], r, frame[4], frame[5]);
    fault    = damaged ? $urandom_range(0, 10) : -1;
    spot     = $urandom_range(0, 6);
    case (fault)
      0: frame[0] ^= 8'($urandom_range(1, 255));
      1: frame[2] ^= 8'($urandom_range(1, 255));
      2: frame[3] ^= 8'($urandom_range(1, 255));
      3: frame[6] ^= 8'($urandom_range(1, 255));
      default: ;
    endcase
    n_bytes = (fault == 5) ? $urandom_range(0, 6) : 7;
    send_item(svrlf_pkg::ModeReadReq, r, 16'($urandom), 8'($urandom));
    for (int i = 0; i < n_bytes; i++) begin
      if (fault == 8 && i == spot) begin
        send_item(svrlf_pkg::ModeNoServo, 8'($urandom), 16'($urandom), 8'($urandom));
        return;
      end
      if (fault == 9 && i == spot) begin
        req = $urandom_range(0, 1) ? svrlf_pkg::ModeWriteReq : svrlf_pkg::ModeReadReq;
        send_item(req, 8'($urandom), 16'($urandom), 8'($urandom));
      end
      if (fault == 10 && i == spot)
        send_item(ModeUnused, 8'($urandom), 16'($urandom), 8'($urandom));
      send_item((fault == 4 && i == spot) ? svrlf_pkg::ModeRxError : svrlf_pkg::ModeRxByte,
                8'($urandom), 16'($urandom), frame[i]);
    end
    if (fault == 6)
      repeat ($urandom_range(1, 3))
        send_item(svrlf_pkg::ModeRxByte, 8'($urandom), 16'($urandom), 8'($urandom));
    send_item((fault == 7) ? svrlf_pkg::ModeEndLow : svrlf_pkg::ModeEndHigh,
              8'($urandom), 16'($urandom), 8'($urandom));
  endtask

  // Bytes and line events with no read pending must produce nothing.
  task automatic test_idle_events();
    send_item(svrlf_pkg::ModeRxByte, 8'hFF, 16'hFFFF, 8'hFF);
    send_item(svrlf_pkg::ModeNoServo, 8'h00, 16'h0000, 8'h00);
    send_item(svrlf_pkg::ModeEndLow, 8'hFF, 16'hFFFF, 8'h69);
    wait_for_drain();
  endtask

  // Write frames at the field extremes; the all-ones case wraps the sum.
  task automatic test_write_frames();
    send_item(svrlf_pkg::ModeWriteReq, 8'hFF, 16'hFFFF, 8'h00);
    send_item(svrlf_pkg::ModeWriteReq, 8'h00, 16'h0000, 8'hFF);
    wait_for_drain();
  endtask

  // Hand-built replies: a good one with requests in the busy window, an
  // extra byte and an unused mode, then an errored short reply, a lost
  // servo, and a low line with no bytes at all.
  task automatic test_reply_checks();
    logic [7:0] ck;
    ck = reply_sum(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_item(svrlf_pkg::ModeReadReq, 8'hFF, 16'h0000, 8'h00);
    send_item(svrlf_pkg::ModeWriteReq, 8'h12, 16'hA55A, 8'h00);
    send_item(svrlf_pkg::ModeReadReq, 8'h34, 16'h0000, 8'h00);
    send_item(svrlf_pkg::ModeRxByte, 8'h00, 16'h0000, svrlf_pkg::HdrResponse);
    send_item(svrlf_pkg::ModeRxByte, 8'h00, 16'h0000, 8'hFF);
    send_item(svrlf_pkg::ModeRxByte, 8'h00, 16'h0000, 8'hFF);
    send_item(svrlf_pkg::ModeRxByte, 8'h00, 16'h0000, svrlf_pkg::LenTwo);
    send_item(svrlf_pkg::ModeRxByte, 8'h00, 16'h0000, 8'hFF);
    send_item(svrlf_pkg::ModeRxByte, 8'h00, 16'h0000, 8'hFF);
    send_item(svrlf_pkg::ModeRxByte, 8'h00, 16'h0000, ck);
    send_item(svrlf_pkg::ModeRxByte, 8'h00, 16'h0000, 8'h5A);
    send_item(ModeUnused, 8'hFF, 16'hFFFF, 8'hFF);
    send_item(svrlf_pkg::ModeEndHigh, 8'h00, 16'h0000, 8'h00);
    send_item(svrlf_pkg::ModeReadReq, 8'h00, 16'h0000, 8'h00);
    send_item(svrlf_pkg::ModeRxError, 8'h00, 16'h0000, svrlf_pkg::HdrResponse);
    send_item(svrlf_pkg::ModeEndHigh, 8'h00, 16'h0000, 8'h00);
    send_item(svrlf_pkg::ModeReadReq, 8'h5A, 16'h0000, 8'h00);
    send_item(svrlf_pkg::ModeNoServo, 8'h00, 16'h0000, 8'h00);
    send_item(svrlf_pkg::ModeReadReq, 8'hA5, 16'h0000, 8'h00);
    send_item(svrlf_pkg::ModeEndLow, 8'h00, 16'h0000, 8'h00);
    wait_for_drain();
  endtask

  // A stretch where neither side idles, so the block runs at full rate.
  task automatic test_calm_traffic();
    calm = 1'b1;
    repeat (6) begin
      run_read_exchange(1'b0);
      send_item(svrlf_pkg::ModeWriteReq, pick_byte(), {pick_byte(), pick_byte()},
                8'($urandom));
    end
    wait_for_drain();
    calm = 1'b0;
  endtask

  // The receiver holds off while writes keep coming, so the command queue
  // fills and full must hold the sender back until popping resumes.
  task automatic test_fill_and_stall();
    hold_request = StallCycles;
    repeat (12)
      send_item(svrlf_pkg::ModeWriteReq, 8'($urandom), 16'($urandom), 8'($urandom));
    wait_for_drain();
  endtask

  // Mostly complete read exchanges, a third of them damaged, mixed with
  // writes, raw noise on every mode, and now and then a full drain.
  task automatic test_random_traffic();
    int sel;
    while (items_sent < ItemsTarget) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) run_read_exchange(sel < 15);
      else if (sel < 70)
        send_item(svrlf_pkg::ModeWriteReq, pick_byte(), {pick_byte(), pick_byte()},
                  8'($urandom));
      else if (sel < 98)
        send_item(3'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
      else wait_for_drain();
    end
    wait_for_drain();
  endtask

  // Receiver hold-off, counted in cycles apart from the sender.
  always begin
    wait (hold_request > 0);
    rx_hold = 1'b1;
    repeat (hold_request) @(posedge clk_i);
    rx_hold      = 1'b0;
    hold_request = 0;
  end

  // Pop is driven at the falling edge like every other input.
  always @(negedge clk_i) begin
    if (rx_hold) pop = 1'b0;
    else if (calm) pop = 1'b1;
    else pop = ($urandom_range(0, 99) >= IdlePct);
  end

  task automatic report_mismatch(string what, svrlf_pkg::res_t want, svrlf_pkg::res_t got);
    if (mismatches < 10) begin
      $display("%0t mismatch (%s): expected kind=%0d tx=%02h last=%0d st=%0d val=%04h",
               $realtime, what, want.kind, want.tx_byte, want.last, want.status,
               want.read_value);
      $display("  got kind=%0d tx=%02h last=%0d st=%0d val=%04h",
               got.kind, got.tx_byte, got.last, got.status, got.read_value);
    end
    mismatches++;
  endtask

  // Result checker: a result transaction is taken at each rising edge with
  // pop high and empty low, and compared field by field with the oldest
  // expectation.
  always @(posedge clk_i) begin : check_results
    svrlf_pkg::res_t want;
    svrlf_pkg::res_t got;
    if (rst_ni && pop && !empty) begin
      got = {kind_o, tx_byte_o, last_o, status_o, read_value_o};
      if (link_results.size() == 0) begin
        report_mismatch("no result expected", '0, got);
      end else begin
        want = link_results.pop_front();
        if (got.kind !== want.kind || got.tx_byte !== want.tx_byte ||
            got.last !== want.last || got.status !== want.status ||
            got.read_value !== want.read_value)
          report_mismatch("field", want, got);
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL servo_register_link_framer_core");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_idle_events();
    test_write_frames();
    test_reply_checks();
    test_calm_traffic();
    test_fill_and_stall();
    test_random_traffic();
    if (mismatches == 0 && link_results.size() == 0) begin
      $display("PASS servo_register_link_framer_core");
    end else begin
      $display("FAIL servo_register_link_framer_core");
    end
    $finish;
  end

endmodule
